### design/blg_pkg.sv
// Shared types and constants for the Bresenham line pixel generator.
// No dependencies; used by blg_step and bresenham_line_pixel_generator.
package blg_pkg;

  localparam int unsigned COLOR_BITS = 24;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_e;

  typedef struct packed {
    logic x_step_neg;
    logic y_step_neg;
    logic x_major;
    logic line_active;
  } line_flags_t;

endpackage

### design/bresenham_line_pixel_generator.sv
// Bresenham line rasterizer: one word in, at most one pixel word out. A word with
// tuser = 0 loads a line and returns its start pixel; tuser = 1 returns the next
// pixel, or nothing when no line is active. Throughput is one word per clock while
// the output is not stalled by m_axis_tready: a taken word sits in the input
// register until it can advance, and the combinational accumulator and coordinate
// update then feeds the output register. tlast marks the line's end point.
// Top level; depends on blg_pkg and blg_step.
module bresenham_line_pixel_generator #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // start_x, start_y, end_x, end_y, pixel_color, zero pad
  input  logic [((4*COORD_BITS+blg_pkg::COLOR_BITS+7)/8)*8-1:0] s_axis_tdata,
  // op
  input  logic s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // pixel_x, pixel_y, out_color, zero pad
  output logic [((2*COORD_BITS+blg_pkg::COLOR_BITS+7)/8)*8-1:0] m_axis_tdata,
  // last_pixel
  output logic m_axis_tlast
);

  localparam int unsigned CB    = COORD_BITS;
  localparam int unsigned CLR   = blg_pkg::COLOR_BITS;
  localparam int unsigned OUT_W = ((2*CB+CLR+7)/8)*8;

  logic                  in_valid_q;
  blg_pkg::op_e          in_op_q;
  logic signed [CB-1:0]  in_sx_q, in_sy_q, in_ex_q, in_ey_q;
  logic [CLR-1:0]        in_color_q;
  logic                  adv;

  logic signed [CB-1:0]  cur_x_q, cur_y_q, cur_x_d, cur_y_d;
  logic [CB-1:0]         abs_dx_q, abs_dy_q, abs_dx_d, abs_dy_d;
  logic [CB:0]           error_acc_q, error_acc_d;
  logic [CB-1:0]         steps_left_q, steps_left_d;
  logic [CLR-1:0]        line_color_q, line_color_d;
  blg_pkg::line_flags_t  flags_q, flags_d;
  logic                  emit, last;

  logic                  out_valid_q;
  logic [CB-1:0]         pix_x_q, pix_y_q;
  logic [CLR-1:0]        pix_color_q;
  logic                  pix_last_q;

  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_op_q    <= blg_pkg::op_e'(s_axis_tuser);
      in_sx_q    <= s_axis_tdata[CB-1:0];
      in_sy_q    <= s_axis_tdata[2*CB-1:CB];
      in_ex_q    <= s_axis_tdata[3*CB-1:2*CB];
      in_ey_q    <= s_axis_tdata[4*CB-1:3*CB];
      in_color_q <= s_axis_tdata[4*CB+CLR-1:4*CB];
    end
  end

  blg_step #(
    .COORD_BITS(CB)
  ) u_step (
    .op_i         (in_op_q),
    .start_x_i    (in_sx_q),
    .start_y_i    (in_sy_q),
    .end_x_i      (in_ex_q),
    .end_y_i      (in_ey_q),
    .pixel_color_i(in_color_q),
    .cur_x_i      (cur_x_q),
    .cur_y_i      (cur_y_q),
    .abs_dx_i     (abs_dx_q),
    .abs_dy_i     (abs_dy_q),
    .error_acc_i  (error_acc_q),
    .steps_left_i (steps_left_q),
    .line_color_i (line_color_q),
    .flags_i      (flags_q),
    .cur_x_o      (cur_x_d),
    .cur_y_o      (cur_y_d),
    .abs_dx_o     (abs_dx_d),
    .abs_dy_o     (abs_dy_d),
    .error_acc_o  (error_acc_d),
    .steps_left_o (steps_left_d),
    .line_color_o (line_color_d),
    .flags_o      (flags_d),
    .emit_o       (emit),
    .last_o       (last)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q      <= '0;
      cur_y_q      <= '0;
      abs_dx_q     <= '0;
      abs_dy_q     <= '0;
      error_acc_q  <= '0;
      steps_left_q <= '0;
      line_color_q <= '0;
      flags_q      <= '0;
    end else if (adv) begin
      cur_x_q      <= cur_x_d;
      cur_y_q      <= cur_y_d;
      abs_dx_q     <= abs_dx_d;
      abs_dy_q     <= abs_dy_d;
      error_acc_q  <= error_acc_d;
      steps_left_q <= steps_left_d;
      line_color_q <= line_color_d;
      flags_q      <= flags_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= emit;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit) begin
      pix_x_q     <= cur_x_d;
      pix_y_q     <= cur_y_d;
      pix_color_q <= line_color_d;
      pix_last_q  <= last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'({pix_color_q, pix_y_q, pix_x_q});
  assign m_axis_tlast  = pix_last_q;

  a_active_has_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags_q.line_active |-> steps_left_q != '0)
    else $error("active line with no steps left");

  a_err_below_major: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags_q.line_active |->
      error_acc_q < {1'b0, (flags_q.x_major ? abs_dx_q : abs_dy_q)})
    else $error("error accumulator not below major delta");

  a_last_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && emit && last) |=> !flags_q.line_active)
    else $error("line still active after its last pixel");

  a_stall_holds_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !adv) |=> in_valid_q)
    else $error("pending word dropped while output stalled");

endmodule

### design/blg_step.sv
// Combinational line setup and Bresenham step update.
// Depends on blg_pkg for the op code and the line flag struct.
module blg_step #(
  parameter int unsigned COORD_BITS = 12
) (
  input  blg_pkg::op_e                    op_i,
  input  logic signed [COORD_BITS-1:0]    start_x_i,
  input  logic signed [COORD_BITS-1:0]    start_y_i,
  input  logic signed [COORD_BITS-1:0]    end_x_i,
  input  logic signed [COORD_BITS-1:0]    end_y_i,
  input  logic [blg_pkg::COLOR_BITS-1:0]  pixel_color_i,
  input  logic signed [COORD_BITS-1:0]    cur_x_i,
  input  logic signed [COORD_BITS-1:0]    cur_y_i,
  input  logic [COORD_BITS-1:0]           abs_dx_i,
  input  logic [COORD_BITS-1:0]           abs_dy_i,
  input  logic [COORD_BITS:0]             error_acc_i,
  input  logic [COORD_BITS-1:0]           steps_left_i,
  input  logic [blg_pkg::COLOR_BITS-1:0]  line_color_i,
  input  blg_pkg::line_flags_t            flags_i,
  output logic signed [COORD_BITS-1:0]    cur_x_o,
  output logic signed [COORD_BITS-1:0]    cur_y_o,
  output logic [COORD_BITS-1:0]           abs_dx_o,
  output logic [COORD_BITS-1:0]           abs_dy_o,
  output logic [COORD_BITS:0]             error_acc_o,
  output logic [COORD_BITS-1:0]           steps_left_o,
  output logic [blg_pkg::COLOR_BITS-1:0]  line_color_o,
  output blg_pkg::line_flags_t            flags_o,
  output logic                            emit_o,
  output logic                            last_o
);

  localparam logic [COORD_BITS-1:0] ONE = {{(COORD_BITS-1){1'b0}}, 1'b1};

  logic signed [COORD_BITS:0] ld_dx;
  logic signed [COORD_BITS:0] ld_dy;
  logic [COORD_BITS:0]        ld_adx_w;
  logic [COORD_BITS:0]        ld_ady_w;
  logic [COORD_BITS-1:0]      ld_adx;
  logic [COORD_BITS-1:0]      ld_ady;
  logic                       ld_xmaj;
  logic [COORD_BITS-1:0]      ld_major;
  logic [COORD_BITS-1:0]      st_major;
  logic [COORD_BITS-1:0]      st_minor;
  logic [COORD_BITS:0]        st_sum;
  logic                       st_mm;
  logic                       st_mx;
  logic                       st_my;
  logic [COORD_BITS-1:0]      st_steps;

  assign ld_dx    = $signed({end_x_i[COORD_BITS-1], end_x_i})
                  - $signed({start_x_i[COORD_BITS-1], start_x_i});
  assign ld_dy    = $signed({end_y_i[COORD_BITS-1], end_y_i})
                  - $signed({start_y_i[COORD_BITS-1], start_y_i});
  assign ld_adx_w = ld_dx[COORD_BITS] ? -ld_dx : ld_dx;
  assign ld_ady_w = ld_dy[COORD_BITS] ? -ld_dy : ld_dy;
  assign ld_adx   = ld_adx_w[COORD_BITS-1:0];
  assign ld_ady   = ld_ady_w[COORD_BITS-1:0];
  assign ld_xmaj  = ld_adx > ld_ady;
  assign ld_major = ld_xmaj ? ld_adx : ld_ady;

  assign st_major = flags_i.x_major ? abs_dx_i : abs_dy_i;
  assign st_minor = flags_i.x_major ? abs_dy_i : abs_dx_i;
  assign st_sum   = error_acc_i + {1'b0, st_minor};
  assign st_mm    = st_sum >= {1'b0, st_major};
  assign st_mx    = flags_i.x_major || st_mm;
  assign st_my    = !flags_i.x_major || st_mm;
  assign st_steps = steps_left_i - ONE;

  always_comb begin
    cur_x_o      = cur_x_i;
    cur_y_o      = cur_y_i;
    abs_dx_o     = abs_dx_i;
    abs_dy_o     = abs_dy_i;
    error_acc_o  = error_acc_i;
    steps_left_o = steps_left_i;
    line_color_o = line_color_i;
    flags_o      = flags_i;
    emit_o       = 1'b0;
    last_o       = 1'b0;
    unique case (op_i)
      blg_pkg::OP_LOAD: begin
        cur_x_o             = start_x_i;
        cur_y_o             = start_y_i;
        abs_dx_o            = ld_adx;
        abs_dy_o            = ld_ady;
        error_acc_o         = {2'b00, ld_major[COORD_BITS-1:1]};
        steps_left_o        = ld_major;
        line_color_o        = pixel_color_i;
        flags_o.x_step_neg  = ld_dx[COORD_BITS] || (ld_dx == '0);
        flags_o.y_step_neg  = ld_dy[COORD_BITS] || (ld_dy == '0);
        flags_o.x_major     = ld_xmaj;
        flags_o.line_active = ld_major != '0;
        emit_o              = 1'b1;
        last_o              = ld_major == '0;
      end
      blg_pkg::OP_STEP: begin
        if (flags_i.line_active) begin
          error_acc_o = st_mm ? (st_sum - {1'b0, st_major}) : st_sum;
          if (st_mx) begin
            cur_x_o = cur_x_i + (flags_i.x_step_neg ? '1 : ONE);
          end
          if (st_my) begin
            cur_y_o = cur_y_i + (flags_i.y_step_neg ? '1 : ONE);
          end
          steps_left_o        = st_steps;
          flags_o.line_active = st_steps != '0;
          emit_o              = 1'b1;
          last_o              = st_steps == '0;
        end
      end
      default: begin
        emit_o = 1'b0;
      end
    endcase
  end

endmodule

### bench/bresenham_line_pixel_generator_test.sv
// Self-checking bench for bresenham_line_pixel_generator: drives line loads and pixel requests
// with random gaps and back-pressure, and compares every pixel word against a built-in predictor.
// Depends on blg_pkg and the bresenham_line_pixel_generator RTL.
`timescale 1ns / 1ps

module bresenham_line_pixel_generator_test;

  localparam int CW = 12;
  localparam int IW = ((4 * CW + blg_pkg::COLOR_BITS + 7) / 8) * 8;
  localparam int OW = ((2 * CW + blg_pkg::COLOR_BITS + 7) / 8) * 8;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [blg_pkg::COLOR_BITS-1:0] color;
    logic last;
  } pixel_t;

  class pixel_scoreboard;
    logic signed [CW-1:0] cur_x;
    logic signed [CW-1:0] cur_y;
    logic [CW-1:0] abs_dx;
    logic [CW-1:0] abs_dy;
    logic [CW:0] error_acc;
    logic [CW-1:0] steps_left;
    logic [blg_pkg::COLOR_BITS-1:0] line_color;
    blg_pkg::line_flags_t flags;
    pixel_t pending_pixels[$];
    int unsigned errors;

    function new();
      cur_x = '0;
      cur_y = '0;
      abs_dx = '0;
      abs_dy = '0;
      error_acc = '0;
      steps_left = '0;
      line_color = '0;
      flags = '0;
      errors = 0;
    endfunction

    function void flag_error(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void push_pixel(logic last);
      pixel_t p;
      p.x = cur_x;
      p.y = cur_y;
      p.color = line_color;
      p.last = last;
      pending_pixels.push_back(p);
    endfunction

    // Advance the line state for one accepted word; return 1 when it yields a pixel.
    function bit note_word(blg_pkg::op_e op, logic [IW-1:0] data);
      logic signed [CW-1:0] sx, sy, ex, ey;
      int dx, dy;
      logic [CW-1:0] major, minor;
      logic move;
      if (op == blg_pkg::OP_LOAD) begin
        sx = data[CW-1:0];
        sy = data[2*CW-1:CW];
        ex = data[3*CW-1:2*CW];
        ey = data[4*CW-1:3*CW];
        dx = int'(ex) - int'(sx);
        dy = int'(ey) - int'(sy);
        cur_x = sx;
        cur_y = sy;
        flags.x_step_neg = !(dx > 0);
        flags.y_step_neg = !(dy > 0);
        abs_dx = CW'((dx < 0) ? -dx : dx);
        abs_dy = CW'((dy < 0) ? -dy : dy);
        flags.x_major = abs_dx > abs_dy;
        major = flags.x_major ? abs_dx : abs_dy;
        error_acc = {1'b0, major >> 1};
        steps_left = major;
        line_color = data[4*CW+blg_pkg::COLOR_BITS-1:4*CW];
        flags.line_active = major != 0;
        push_pixel(!flags.line_active);
        return 1'b1;
      end
      if (!flags.line_active) return 1'b0;
      major = flags.x_major ? abs_dx : abs_dy;
      minor = flags.x_major ? abs_dy : abs_dx;
      error_acc = error_acc + minor;
      move = error_acc >= major;
      if (move) error_acc = error_acc - major;
      if (flags.x_major || move) cur_x = CW'(flags.x_step_neg ? cur_x - 1 : cur_x + 1);
      if (!flags.x_major || move) cur_y = CW'(flags.y_step_neg ? cur_y - 1 : cur_y + 1);
      steps_left = steps_left - 1'b1;
      if (steps_left == 0) flags.line_active = 1'b0;
      push_pixel(steps_left == 0);
      return 1'b1;
    endfunction

    function void check_pixel(logic [OW-1:0] data, logic last);
      pixel_t exp_p;
      pixel_t got;
      got.x = data[CW-1:0];
      got.y = data[2*CW-1:CW];
      got.color = data[2*CW+blg_pkg::COLOR_BITS-1:2*CW];
      got.last = last;
      if (pending_pixels.size() == 0) begin
        flag_error($sformatf("unexpected pixel x=%0d y=%0d color=%06h last=%0b",
                             got.x, got.y, got.color, got.last));
        return;
      end
      exp_p = pending_pixels.pop_front();
      if (got.x !== exp_p.x || got.y !== exp_p.y || got.color !== exp_p.color ||
          got.last !== exp_p.last)
        flag_error($sformatf({"pixel mismatch: expected x=%0d y=%0d color=%06h last=%0b, ",
                              "got x=%0d y=%0d color=%06h last=%0b"},
                             exp_p.x, exp_p.y, exp_p.color, exp_p.last,
                             got.x, got.y, got.color, got.last));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [IW-1:0] s_axis_tdata;
  logic s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [OW-1:0] m_axis_tdata;
  logic m_axis_tlast;

  pixel_scoreboard sb;
  bit burst;
  int unsigned words_with_pixel;

  bresenham_line_pixel_generator #(.COORD_BITS(CW)) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_word(input blg_pkg::op_e op, input logic [IW-1:0] data);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = op;
    s_axis_tdata = data;
    do @(posedge clk_i); while (!s_axis_tready);
    if (sb.note_word(op, data)) words_with_pixel++;
    @(negedge clk_i);
  endtask

  task automatic load_line(input int sx, input int sy, input int ex, input int ey,
                           input logic [blg_pkg::COLOR_BITS-1:0] color);
    send_word(blg_pkg::OP_LOAD, {color, CW'(ey), CW'(ex), CW'(sy), CW'(sx)});
  endtask

  // Fill the ignored coordinate and color bits with noise.
  task automatic step_pixel();
    logic [95:0] junk;
    junk = {$urandom, $urandom, $urandom};
    send_word(blg_pkg::OP_STEP, junk[IW-1:0]);
  endtask

  function automatic int near(int base);
    int v;
    v = base + int'($urandom_range(0, 40)) - 20;
    if (v > 2047) v = 2047;
    if (v < -2048) v = -2048;
    return v;
  endfunction

  initial begin : pixel_sink
    int unsigned stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = burst ? 0 : $urandom_range(0, 6);
      if (stall != 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_pixel(m_axis_tdata, m_axis_tlast);
      @(negedge clk_i);
    end
  end

  initial begin : line_source
    int sx, sy, n, kind;
    sb = new();
    burst = 1'b0;
    words_with_pixel = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // no line yet, then a zero-length line
    step_pixel();
    load_line(5, 5, 5, 5, 24'hFFFFFF);
    step_pixel();
    // diagonal tie goes to y
    load_line(0, 0, 3, 3, 24'h123456);
    repeat (3) step_pixel();
    // x-major, decreasing x
    load_line(2047, -2048, 2043, -2046, 24'hA5A5A5);
    repeat (4) step_pixel();
    // vertical, decreasing y
    load_line(-2048, 2047, -2048, 2044, 24'h5A5A5A);
    repeat (3) step_pixel();
    // horizontal, then a request past the end
    load_line(10, 0, 12, 0, 24'h00FF00);
    repeat (3) step_pixel();
    // full-range diagonals, cut short by a reload
    load_line(-2048, -2048, 2047, 2047, 24'h000000);
    repeat (2) step_pixel();
    load_line(2047, 2047, -2048, -2048, 24'hFFFFFF);
    step_pixel();

    while (words_with_pixel < 600) begin
      if ($urandom_range(0, 24) == 0) burst = !burst;
      kind = $urandom_range(0, 9);
      sx = $signed(12'($urandom));
      sy = $signed(12'($urandom));
      if (kind < 7) begin
        load_line(sx, sy, near(sx), near(sy), 24'($urandom));
        n = sb.steps_left;
        if ($urandom_range(0, 5) == 0) n = $urandom_range(0, n);
        else n += $urandom_range(0, 1);
        repeat (n) step_pixel();
      end else if (kind == 7) begin
        load_line(sx, sy, $urandom, $urandom, 24'($urandom));
        repeat ($urandom_range(0, 20)) step_pixel();
      end else if (kind == 8) begin
        load_line(sx, sy, sx, sy, 24'($urandom));
        step_pixel();
      end else begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 1) == 0) step_pixel();
          else load_line($urandom, $urandom, $urandom, $urandom, 24'($urandom));
        end
      end
    end
    s_axis_tvalid = 1'b0;

    while (sb.pending_pixels.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_pixels.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
